FILE: hw/rtl/tfn_pkg.sv
// ----------------------------------------------------------------------------
// tfn_pkg: shared widths, constants and types
// Widths of the triangle normal datapath, derived from the coordinate
// and normal fraction widths; only the shift width is set on its own.
// ----------------------------------------------------------------------------
package tfn_pkg;

	// field widths
	localparam int COORD_BITS       = 24;
	localparam int NORMAL_FRAC_BITS = 14;
	localparam int NORMAL_BITS      = NORMAL_FRAC_BITS + 2;
	localparam int SHIFT_BITS       = 6;
	localparam logic [SHIFT_BITS-1:0] SHIFT_RESET = 6'd40;

	// datapath widths
	localparam int EDGE_BITS = COORD_BITS + 1;
	localparam int PROD_BITS = 2 * EDGE_BITS;
	localparam int HALF_BITS = EDGE_BITS;
	localparam int SQ_BITS   = 2 * PROD_BITS;

	// quotient c^2 * 2^(2F+2) / s and its square root
	localparam int QUO_BITS  = 2 * NORMAL_FRAC_BITS + 3;
	localparam int DIV_STEPS = QUO_BITS;
	localparam int ROOT_BITS = (QUO_BITS + 1) / 2;
	localparam int RAD_BITS  = 2 * ROOT_BITS;
	localparam int REM_BITS  = ROOT_BITS + 2;

	// pipeline depth
	localparam int FRONT_STAGES = 8;
	localparam int LATENCY      = FRONT_STAGES + DIV_STEPS + ROOT_BITS + 1;

	typedef logic [SQ_BITS-1:0]   sq_t;
	typedef logic [PROD_BITS-1:0] mag_t;
	typedef logic [QUO_BITS-1:0]  quo_t;

	// per-item flags that ride along the pipeline
	typedef struct packed {
		logic       kept;
		logic [2:0] neg;
	} meta_t;

endpackage

FILE: hw/rtl/tfn_front.sv
// ----------------------------------------------------------------------------
// tfn_front: edges, cross product, squared lengths and sliver test
// Eight register stages from the corners to the squared cross components,
// their sum and the keep decision.
// ----------------------------------------------------------------------------
module tfn_front (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	input  logic signed [tfn_pkg::COORD_BITS-1:0]   a_x,
	input  logic signed [tfn_pkg::COORD_BITS-1:0]   a_y,
	input  logic signed [tfn_pkg::COORD_BITS-1:0]   a_z,
	input  logic signed [tfn_pkg::COORD_BITS-1:0]   b_x,
	input  logic signed [tfn_pkg::COORD_BITS-1:0]   b_y,
	input  logic signed [tfn_pkg::COORD_BITS-1:0]   b_z,
	input  logic signed [tfn_pkg::COORD_BITS-1:0]   c_x,
	input  logic signed [tfn_pkg::COORD_BITS-1:0]   c_y,
	input  logic signed [tfn_pkg::COORD_BITS-1:0]   c_z,
	input  logic [tfn_pkg::SHIFT_BITS-1:0]          shift,
	output logic                                    out_valid,
	output tfn_pkg::meta_t                          out_meta,
	output tfn_pkg::sq_t                            out_c2 [3],
	output tfn_pkg::sq_t                            out_s
);

	localparam int EB = tfn_pkg::EDGE_BITS;
	localparam int PB = tfn_pkg::PROD_BITS;
	localparam int HB = tfn_pkg::HALF_BITS;

	logic signed [tfn_pkg::COORD_BITS-1:0] av [3];
	logic signed [tfn_pkg::COORD_BITS-1:0] bv [3];
	logic signed [tfn_pkg::COORD_BITS-1:0] cv [3];

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;

	logic signed [EB-1:0] e1_s1 [3];
	logic signed [EB-1:0] e2_s1 [3];
	logic signed [PB-1:0] pc_s2 [6];
	logic signed [PB-1:0] sq1_s2 [3];
	logic signed [PB-1:0] sq2_s2 [3];
	logic signed [PB-1:0] cr_s3 [3];
	tfn_pkg::mag_t        l1_s3, l2_s3;
	tfn_pkg::mag_t        cabs_s4 [3];
	logic [2:0]           neg_s4;
	tfn_pkg::mag_t        l1_s4, l2_s4;
	tfn_pkg::mag_t        hh_s5 [3];
	tfn_pkg::mag_t        hl_s5 [3];
	tfn_pkg::mag_t        ll_s5 [3];
	tfn_pkg::mag_t        phh_s5, phl_s5, plh_s5, pll_s5;
	logic [2:0]           neg_s5;
	tfn_pkg::sq_t         c2_s6 [3];
	tfn_pkg::sq_t         p_s6;
	logic [2:0]           neg_s6;
	tfn_pkg::sq_t         c2_s7 [3];
	tfn_pkg::sq_t         s_s7, p_s7;
	logic [2:0]           neg_s7;
	tfn_pkg::sq_t         c2_s8 [3];
	tfn_pkg::sq_t         s_s8;
	tfn_pkg::meta_t       meta_s8;

	assign av[0] = a_x; assign av[1] = a_y; assign av[2] = a_z;
	assign bv[0] = b_x; assign bv[1] = b_y; assign bv[2] = b_z;
	assign cv[0] = c_x; assign cv[1] = c_y; assign cv[2] = c_z;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8} <= '0;
		end else begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8} <=
				{in_valid, v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7};
		end
	end

	// stage 1: edge vectors
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			e1_s1[i] <= EB'(bv[i]) - EB'(av[i]);
			e2_s1[i] <= EB'(cv[i]) - EB'(av[i]);
		end
	end

	// stage 2: cross partial products and squared edge terms
	always_ff @(posedge clk) begin
		pc_s2[0] <= e1_s1[1] * e2_s1[2];
		pc_s2[1] <= e1_s1[2] * e2_s1[1];
		pc_s2[2] <= e1_s1[2] * e2_s1[0];
		pc_s2[3] <= e1_s1[0] * e2_s1[2];
		pc_s2[4] <= e1_s1[0] * e2_s1[1];
		pc_s2[5] <= e1_s1[1] * e2_s1[0];
		for (int i = 0; i < 3; i++) begin
			sq1_s2[i] <= e1_s1[i] * e1_s1[i];
			sq2_s2[i] <= e2_s1[i] * e2_s1[i];
		end
	end

	// stage 3: cross components and squared edge lengths
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			cr_s3[i] <= pc_s2[2*i] - pc_s2[2*i+1];
		end
		l1_s3 <= $unsigned(sq1_s2[0]) + $unsigned(sq1_s2[1]) + $unsigned(sq1_s2[2]);
		l2_s3 <= $unsigned(sq2_s2[0]) + $unsigned(sq2_s2[1]) + $unsigned(sq2_s2[2]);
	end

	// stage 4: magnitude and sign of each cross component
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			neg_s4[i]  <= cr_s3[i][PB-1];
			cabs_s4[i] <= cr_s3[i][PB-1] ? $unsigned(-cr_s3[i]) : $unsigned(cr_s3[i]);
		end
		l1_s4 <= l1_s3;
		l2_s4 <= l2_s3;
	end

	// stage 5: half-width partial products for the wide squares and the length product
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			hh_s5[i] <= cabs_s4[i][PB-1:HB] * cabs_s4[i][PB-1:HB];
			hl_s5[i] <= cabs_s4[i][PB-1:HB] * cabs_s4[i][HB-1:0];
			ll_s5[i] <= cabs_s4[i][HB-1:0] * cabs_s4[i][HB-1:0];
		end
		phh_s5 <= l1_s4[PB-1:HB] * l2_s4[PB-1:HB];
		phl_s5 <= l1_s4[PB-1:HB] * l2_s4[HB-1:0];
		plh_s5 <= l1_s4[HB-1:0] * l2_s4[PB-1:HB];
		pll_s5 <= l1_s4[HB-1:0] * l2_s4[HB-1:0];
		neg_s5 <= neg_s4;
	end

	// stage 6: assemble squared components and the edge length product
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			c2_s6[i] <= (tfn_pkg::sq_t'(hh_s5[i]) << PB) + (tfn_pkg::sq_t'(hl_s5[i]) << (HB + 1))
				+ tfn_pkg::sq_t'(ll_s5[i]);
		end
		p_s6 <= (tfn_pkg::sq_t'(phh_s5) << PB)
			+ ((tfn_pkg::sq_t'(phl_s5) + tfn_pkg::sq_t'(plh_s5)) << HB)
			+ tfn_pkg::sq_t'(pll_s5);
		neg_s6 <= neg_s5;
	end

	// stage 7: squared cross length
	always_ff @(posedge clk) begin
		s_s7   <= c2_s6[0] + c2_s6[1] + c2_s6[2];
		c2_s7  <= c2_s6;
		p_s7   <= p_s6;
		neg_s7 <= neg_s6;
	end

	// stage 8: sliver test, s * 2^shift > p is s > (p >> shift)
	always_ff @(posedge clk) begin
		meta_s8.kept <= s_s7 > (p_s7 >> shift);
		meta_s8.neg  <= neg_s7;
		c2_s8        <= c2_s7;
		s_s8         <= s_s7;
	end

	assign out_valid = v_s8;
	assign out_meta  = meta_s8;
	assign out_c2    = c2_s8;
	assign out_s     = s_s8;

endmodule

FILE: hw/rtl/tfn_div.sv
// ----------------------------------------------------------------------------
// tfn_div: pipelined restoring divider
// One quotient bit per stage of floor(c^2 * 2^(QUO_BITS-1) / s) for all
// three components, which share the divisor.
// ----------------------------------------------------------------------------
module tfn_div (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  tfn_pkg::meta_t in_meta,
	input  tfn_pkg::sq_t   in_c2 [3],
	input  tfn_pkg::sq_t   in_s,
	output logic           out_valid,
	output tfn_pkg::meta_t out_meta,
	output tfn_pkg::quo_t  out_q [3]
);

	localparam int NS = tfn_pkg::DIV_STEPS;
	localparam int SB = tfn_pkg::SQ_BITS;
	localparam int QB = tfn_pkg::QUO_BITS;

	logic           vld_w  [NS];
	tfn_pkg::meta_t meta_w [NS];
	tfn_pkg::sq_t   den_w  [NS];
	tfn_pkg::sq_t   rem_w  [NS][3];
	tfn_pkg::quo_t  quo_w  [NS][3];

	for (genvar k = 0; k < NS; k++) begin : g_step
		logic           vld_in;
		tfn_pkg::meta_t meta_in;
		tfn_pkg::sq_t   den_in;
		tfn_pkg::quo_t  quo_in [3];
		logic [SB:0]    trial  [3];
		logic           vld_s;
		tfn_pkg::meta_t meta_s;
		tfn_pkg::sq_t   den_s;
		tfn_pkg::sq_t   rem_s [3];
		tfn_pkg::quo_t  quo_s [3];

		// first step takes c^2 as is, later ones double the remainder
		if (k == 0) begin : g_first
			assign vld_in  = in_valid;
			assign meta_in = in_meta;
			assign den_in  = in_s;
			for (genvar j = 0; j < 3; j++) begin : g_lane
				assign trial[j]  = {1'b0, in_c2[j]};
				assign quo_in[j] = '0;
			end
		end else begin : g_next
			assign vld_in  = vld_w[k-1];
			assign meta_in = meta_w[k-1];
			assign den_in  = den_w[k-1];
			for (genvar j = 0; j < 3; j++) begin : g_lane
				assign trial[j]  = {rem_w[k-1][j], 1'b0};
				assign quo_in[j] = quo_w[k-1][j];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s <= 1'b0;
			end else begin
				vld_s <= vld_in;
			end
		end

		// compare, subtract and shift in one quotient bit
		always_ff @(posedge clk) begin
			meta_s <= meta_in;
			den_s  <= den_in;
			for (int j = 0; j < 3; j++) begin
				if (trial[j] >= {1'b0, den_in}) begin
					rem_s[j] <= SB'(trial[j] - {1'b0, den_in});
					quo_s[j] <= {quo_in[j][QB-2:0], 1'b1};
				end else begin
					rem_s[j] <= SB'(trial[j]);
					quo_s[j] <= {quo_in[j][QB-2:0], 1'b0};
				end
			end
		end

		assign vld_w[k]  = vld_s;
		assign meta_w[k] = meta_s;
		assign den_w[k]  = den_s;
		for (genvar j = 0; j < 3; j++) begin : g_out
			assign rem_w[k][j] = rem_s[j];
			assign quo_w[k][j] = quo_s[j];
		end
	end

	assign out_valid = vld_w[NS-1];
	assign out_meta  = meta_w[NS-1];
	for (genvar j = 0; j < 3; j++) begin : g_res
		assign out_q[j] = quo_w[NS-1][j];
	end

endmodule

FILE: hw/rtl/tfn_sqrt.sv
// ----------------------------------------------------------------------------
// tfn_sqrt: pipelined integer square root and normal rounding
// One root bit per stage, then the rounded magnitude, sign and drop gating
// in the output register.
// ----------------------------------------------------------------------------
module tfn_sqrt (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	input  tfn_pkg::meta_t                         in_meta,
	input  tfn_pkg::quo_t                          in_q [3],
	output logic                                   done,
	output logic                                   kept,
	output logic signed [tfn_pkg::NORMAL_BITS-1:0] normal_x,
	output logic signed [tfn_pkg::NORMAL_BITS-1:0] normal_y,
	output logic signed [tfn_pkg::NORMAL_BITS-1:0] normal_z
);

	localparam int NS = tfn_pkg::ROOT_BITS;
	localparam int AB = tfn_pkg::RAD_BITS;
	localparam int MB = tfn_pkg::REM_BITS;
	localparam int NB = tfn_pkg::NORMAL_BITS;

	logic           vld_w  [NS];
	tfn_pkg::meta_t meta_w [NS];
	logic [AB-1:0]  rad_w  [NS][3];
	logic [MB-1:0]  rem_w  [NS][3];
	logic [NS-1:0]  root_w [NS][3];

	logic                 done_q, kept_q;
	logic signed [NB-1:0] nrm_q [3];
	logic [NS:0]          rnd   [3];
	logic [NB-1:0]        mag   [3];

	for (genvar k = 0; k < NS; k++) begin : g_step
		logic           vld_in;
		tfn_pkg::meta_t meta_in;
		logic [AB-1:0]  rad_in  [3];
		logic [MB-1:0]  rem_in  [3];
		logic [NS-1:0]  root_in [3];
		logic [MB+1:0]  acc     [3];
		logic [MB+1:0]  tst     [3];
		logic           vld_s;
		tfn_pkg::meta_t meta_s;
		logic [AB-1:0]  rad_s  [3];
		logic [MB-1:0]  rem_s  [3];
		logic [NS-1:0]  root_s [3];

		if (k == 0) begin : g_first
			assign vld_in  = in_valid;
			assign meta_in = in_meta;
			for (genvar j = 0; j < 3; j++) begin : g_lane
				assign rad_in[j]  = AB'(in_q[j]);
				assign rem_in[j]  = '0;
				assign root_in[j] = '0;
			end
		end else begin : g_next
			assign vld_in  = vld_w[k-1];
			assign meta_in = meta_w[k-1];
			for (genvar j = 0; j < 3; j++) begin : g_lane
				assign rad_in[j]  = rad_w[k-1][j];
				assign rem_in[j]  = rem_w[k-1][j];
				assign root_in[j] = root_w[k-1][j];
			end
		end

		// bring down two radicand bits and try root*4+1
		for (genvar j = 0; j < 3; j++) begin : g_try
			assign acc[j] = {rem_in[j], rad_in[j][AB-1:AB-2]};
			assign tst[j] = (MB+2)'({root_in[j], 2'b01});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s <= 1'b0;
			end else begin
				vld_s <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			meta_s <= meta_in;
			for (int j = 0; j < 3; j++) begin
				rad_s[j] <= {rad_in[j][AB-3:0], 2'b00};
				if (acc[j] >= tst[j]) begin
					rem_s[j]  <= MB'(acc[j] - tst[j]);
					root_s[j] <= {root_in[j][NS-2:0], 1'b1};
				end else begin
					rem_s[j]  <= MB'(acc[j]);
					root_s[j] <= {root_in[j][NS-2:0], 1'b0};
				end
			end
		end

		assign vld_w[k]  = vld_s;
		assign meta_w[k] = meta_s;
		for (genvar j = 0; j < 3; j++) begin : g_out
			assign rad_w[k][j]  = rad_s[j];
			assign rem_w[k][j]  = rem_s[j];
			assign root_w[k][j] = root_s[j];
		end
	end

	// largest m with (2m-1)^2 <= q is (root+1)/2
	for (genvar j = 0; j < 3; j++) begin : g_rnd
		assign rnd[j] = (NS+1)'(root_w[NS-1][j]) + (NS+1)'(1);
		assign mag[j] = NB'(rnd[j][NS:1]);
	end

	// output register, strobe for one cycle per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_w[NS-1];
		end
	end

	always_ff @(posedge clk) begin
		kept_q <= meta_w[NS-1].kept;
		for (int j = 0; j < 3; j++) begin
			if (!meta_w[NS-1].kept) begin
				nrm_q[j] <= '0;
			end else if (meta_w[NS-1].neg[j]) begin
				nrm_q[j] <= -$signed(mag[j]);
			end else begin
				nrm_q[j] <= $signed(mag[j]);
			end
		end
	end

	assign done     = done_q;
	assign kept     = kept_q;
	assign normal_x = nrm_q[0];
	assign normal_y = nrm_q[1];
	assign normal_z = nrm_q[2];

endmodule

FILE: hw/rtl/triangle_facet_normal_cull.sv
// ----------------------------------------------------------------------------
// triangle_facet_normal_cull: unit face normal with sliver cull
// Throughput: one triangle per cycle; busy stays low, the pipeline takes
// a new item every cycle. Depth is set by the 8 front stages, the 31-step
// divider, the 16-step square root and the output register.
// Results cannot be held off by the receiver.
// Reset clears all valid bits and loads the shift_q threshold with 40.
// ----------------------------------------------------------------------------
module triangle_facet_normal_cull (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic                                   cfg_write,
	input  logic [tfn_pkg::SHIFT_BITS-1:0]         cfg_data,
	input  logic signed [tfn_pkg::COORD_BITS-1:0]  a_x,
	input  logic signed [tfn_pkg::COORD_BITS-1:0]  a_y,
	input  logic signed [tfn_pkg::COORD_BITS-1:0]  a_z,
	input  logic signed [tfn_pkg::COORD_BITS-1:0]  b_x,
	input  logic signed [tfn_pkg::COORD_BITS-1:0]  b_y,
	input  logic signed [tfn_pkg::COORD_BITS-1:0]  b_z,
	input  logic signed [tfn_pkg::COORD_BITS-1:0]  c_x,
	input  logic signed [tfn_pkg::COORD_BITS-1:0]  c_y,
	input  logic signed [tfn_pkg::COORD_BITS-1:0]  c_z,
	output logic                                   done,
	output logic                                   kept,
	output logic signed [tfn_pkg::NORMAL_BITS-1:0] normal_x,
	output logic signed [tfn_pkg::NORMAL_BITS-1:0] normal_y,
	output logic signed [tfn_pkg::NORMAL_BITS-1:0] normal_z
);

	localparam logic signed [tfn_pkg::NORMAL_BITS-1:0] UNIT =
		tfn_pkg::NORMAL_BITS'(1 << tfn_pkg::NORMAL_FRAC_BITS);

	logic [tfn_pkg::SHIFT_BITS-1:0] shift_q;
	logic                           fr_valid, dv_valid;
	tfn_pkg::meta_t                 fr_meta, dv_meta;
	tfn_pkg::sq_t                   fr_c2 [3];
	tfn_pkg::sq_t                   fr_s;
	tfn_pkg::quo_t                  dv_q [3];

	// fully pipelined, never stalls
	assign busy = 1'b0;

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= tfn_pkg::SHIFT_RESET;
		end else if (cfg_write) begin
			shift_q <= cfg_data;
		end
	end

	tfn_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.a_x       (a_x),
		.a_y       (a_y),
		.a_z       (a_z),
		.b_x       (b_x),
		.b_y       (b_y),
		.b_z       (b_z),
		.c_x       (c_x),
		.c_y       (c_y),
		.c_z       (c_z),
		.shift     (shift_q),
		.out_valid (fr_valid),
		.out_meta  (fr_meta),
		.out_c2    (fr_c2),
		.out_s     (fr_s)
	);

	tfn_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_meta   (fr_meta),
		.in_c2     (fr_c2),
		.in_s      (fr_s),
		.out_valid (dv_valid),
		.out_meta  (dv_meta),
		.out_q     (dv_q)
	);

	tfn_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (dv_valid),
		.in_meta  (dv_meta),
		.in_q     (dv_q),
		.done     (done),
		.kept     (kept),
		.normal_x (normal_x),
		.normal_y (normal_y),
		.normal_z (normal_z)
	);

	// every transfer in gives exactly one result a fixed time later
	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##(tfn_pkg::LATENCY) done)
		else $error("accepted triangle produced no result");

	a_latency_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, tfn_pkg::LATENCY))
		else $error("result without a matching input transfer");

	// dropped triangle carries a zero normal
	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !kept |-> normal_x == '0 && normal_y == '0 && normal_z == '0)
		else $error("dropped triangle has nonzero normal");

	// kept normal is bounded by one and never all zero
	a_kept_unit: assert property (@(posedge clk) disable iff (!arst_n)
		done && kept |-> normal_x <= UNIT && normal_x >= -UNIT
			&& normal_y <= UNIT && normal_y >= -UNIT
			&& normal_z <= UNIT && normal_z >= -UNIT
			&& (normal_x != '0 || normal_y != '0 || normal_z != '0))
		else $error("kept normal out of range");

endmodule
